// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/tli_pkg.sv =====
// ---------------------------------------------------------------------------
// tli_pkg
// Types and constants of the table linear interpolator.
// ---------------------------------------------------------------------------
package tli_pkg;

    localparam int unsigned MAX_POINTS_DEF = 64;
    localparam int unsigned DATA_W         = 32;
    localparam int unsigned ACC_W          = 50;
    localparam int unsigned FRAC_W         = 17;
    localparam int unsigned SEG_W          = 6;
    localparam int unsigned S_TDATA_W      = 104;
    localparam int unsigned M_TDATA_W      = 56;
    localparam int unsigned CFG_IDX_W      = 2;

    localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_USE_FILL    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FILL_VALUE  = 2'd2;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] REGION_INTERIOR = 2'd0;
    localparam logic [1:0] REGION_BELOW    = 2'd1;
    localparam logic [1:0] REGION_ABOVE    = 2'd2;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

endpackage

// ===== rtl/table_linear_interpolator_top.sv =====
// ---------------------------------------------------------------------------
// table_linear_interpolator_top
// Piecewise linear interpolation over a loaded Q16.16 breakpoint table.
// ---------------------------------------------------------------------------
// Channel   Dir  Handshake            Payload
// s_        in   s_tvalid/s_tready    tuser: op; tdata: index, x, y, query
// m_        out  m_tvalid/m_tready    tuser: region; tdata: result, seg, frac
// cfg_      in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A load is written to the table memories from the idle state. A query at or below
// the first x goes to the output register once the first x is read and compared;
// one at or above the last x also has the last x read and compared; an interior
// query adds the one-entry-per-cycle segment scan over the x memory and the
// 17-step divide and 17-step multiply on the shared adder.
// Synchronous active-low reset; table memories are not cleared.
// A finished result waits in the sequencer until the output register is free.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module table_linear_interpolator_top #(
    parameter int unsigned MAX_POINTS = tli_pkg::MAX_POINTS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [5:0] point_index, [37:6] point_x, [69:38] point_y, [101:70] query_value
    input  logic [tli_pkg::S_TDATA_W-1:0]      s_tdata,
    // [0] op
    input  logic [0:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [31:0] result_value, [37:32] segment_end, [54:38] fraction
    output logic [tli_pkg::M_TDATA_W-1:0]      m_tdata,
    // [1:0] region
    output logic [1:0]                         m_tuser,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tli_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tli_pkg::DATA_W-1:0]         cfg_data
);

    localparam int unsigned AW    = $clog2(MAX_POINTS);
    localparam int unsigned CW    = ($clog2(MAX_POINTS + 1) > 7) ? $clog2(MAX_POINTS + 1) : 7;
    localparam int unsigned ACC_W = tli_pkg::ACC_W;

    typedef enum logic [11:0] {
        ST_IDLE = 12'b0000_0000_0001,
        ST_RD0  = 12'b0000_0000_0010,
        ST_CHK0 = 12'b0000_0000_0100,
        ST_CHKN = 12'b0000_0000_1000,
        ST_SCAN = 12'b0000_0001_0000,
        ST_NUM  = 12'b0000_0010_0000,
        ST_DEN  = 12'b0000_0100_0000,
        ST_DY   = 12'b0000_1000_0000,
        ST_DIV  = 12'b0001_0000_0000,
        ST_MUL  = 12'b0010_0000_0000,
        ST_SUM  = 12'b0100_0000_0000,
        ST_DONE = 12'b1000_0000_0000
    } state_t;

    function automatic logic [ACC_W-1:0] sext32(input logic [31:0] val);
        sext32 = {{(ACC_W - 32){val[31]}}, val};
    endfunction

    function automatic logic [ACC_W-1:0] sext33(input logic [32:0] val);
        sext33 = {{(ACC_W - 33){val[32]}}, val};
    endfunction

    // input fields
    logic        s_op;
    logic [5:0]  s_point_index;
    logic [31:0] s_point_x;
    logic [31:0] s_point_y;
    logic [31:0] s_query_value;

    assign s_op          = s_tuser[0];
    assign s_point_index = s_tdata[5:0];
    assign s_point_x     = s_tdata[37:6];
    assign s_point_y     = s_tdata[69:38];
    assign s_query_value = s_tdata[101:70];

    // configuration
    logic [6:0]  point_count_reg;
    logic        use_fill_reg;
    logic [31:0] fill_value_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_count_reg <= 7'd1;
            use_fill_reg    <= 1'b0;
            fill_value_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                tli_pkg::REG_POINT_COUNT: point_count_reg <= cfg_data[6:0];
                tli_pkg::REG_USE_FILL:    use_fill_reg    <= cfg_data[0];
                tli_pkg::REG_FILL_VALUE:  fill_value_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // effective point count, clamped to 1..MAX_POINTS
    logic [CW-1:0] cnt_ext;
    logic [CW-1:0] n_eff;
    logic [CW-1:0] n_m1;

    always_comb begin
        cnt_ext = CW'(point_count_reg);
        priority if (cnt_ext == '0) begin
            n_eff = CW'(1);
        end else if (cnt_ext > CW'(MAX_POINTS)) begin
            n_eff = CW'(MAX_POINTS);
        end else begin
            n_eff = cnt_ext;
        end
        n_m1 = n_eff - CW'(1);
    end

    // table
    logic          wr_en;
    logic [AW-1:0] x_raddr;
    logic [AW-1:0] y_raddr;
    logic [31:0]   x_rdata;
    logic [31:0]   y_rdata;

    tli_table #(
        .MAX_POINTS (MAX_POINTS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (AW'(s_point_index)),
        .wr_x    (s_point_x),
        .wr_y    (s_point_y),
        .x_raddr (x_raddr),
        .y_raddr (y_raddr),
        .x_rdata (x_rdata),
        .y_rdata (y_rdata)
    );

    // shared adder
    tli_pkg::alu_op_t  alu_op;
    logic [ACC_W-1:0]  alu_a;
    logic [ACC_W-1:0]  alu_b;
    logic [ACC_W-1:0]  alu_y;

    tli_alu u_alu (
        .alu_op (alu_op),
        .op_a   (alu_a),
        .op_b   (alu_b),
        .result (alu_y)
    );

    // sequencer and datapath registers
    state_t           state_reg,    state_next;
    logic [31:0]      v_reg,        v_next;
    logic [AW-1:0]    last_reg,     last_next;
    logic [AW-1:0]    k_reg,        k_next;
    logic [31:0]      x_prev_reg,   x_prev_next;
    logic [31:0]      x1_reg,       x1_next;
    logic [31:0]      y0_reg,       y0_next;
    logic [31:0]      y1_reg,       y1_next;
    logic [33:0]      rem_reg,      rem_next;
    logic [32:0]      den_reg,      den_next;
    logic [32:0]      dy_reg,       dy_next;
    logic [16:0]      q_reg,        q_next;
    logic [ACC_W-1:0] acc_reg,      acc_next;
    logic [4:0]       cnt_reg,      cnt_next;
    logic [31:0]      res_reg,      res_next;
    logic [1:0]       region_reg,   region_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [tli_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [1:0]       m_tuser_reg,  m_tuser_next;

    logic             diff_neg;
    logic             diff_zero;
    logic             q_bit;
    logic [31:0]      edge_y;
    logic             interior;

    assign s_tready  = (state_reg == ST_IDLE);
    assign diff_neg  = alu_y[ACC_W-1];
    assign diff_zero = (alu_y == '0);
    assign q_bit     = !alu_y[ACC_W-1];
    assign edge_y    = use_fill_reg ? fill_value_reg : y_rdata;
    assign interior  = (region_reg == tli_pkg::REGION_INTERIOR);

    always_comb begin
        state_next    = state_reg;
        v_next        = v_reg;
        last_next     = last_reg;
        k_next        = k_reg;
        x_prev_next   = x_prev_reg;
        x1_next       = x1_reg;
        y0_next       = y0_reg;
        y1_next       = y1_reg;
        rem_next      = rem_reg;
        den_next      = den_reg;
        dy_next       = dy_reg;
        q_next        = q_reg;
        acc_next      = acc_reg;
        cnt_next      = cnt_reg;
        res_next      = res_reg;
        region_next   = region_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        wr_en         = 1'b0;
        x_raddr       = '0;
        y_raddr       = '0;
        alu_op        = tli_pkg::ALU_SUB;
        alu_a         = '0;
        alu_b         = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_op == tli_pkg::OP_LOAD) begin
                        wr_en = (32'(s_point_index) < 32'(MAX_POINTS));
                    end else begin
                        v_next     = s_query_value;
                        last_next  = n_m1[AW-1:0];
                        state_next = ST_RD0;
                    end
                end
            end
            ST_RD0: begin
                state_next = ST_CHK0;
            end
            ST_CHK0: begin
                alu_a = sext32(v_reg);
                alu_b = sext32(x_rdata);
                if (diff_neg || diff_zero) begin
                    region_next = tli_pkg::REGION_BELOW;
                    res_next    = edge_y;
                    state_next  = ST_DONE;
                end else begin
                    x_prev_next = x_rdata;
                    x_raddr     = last_reg;
                    y_raddr     = last_reg;
                    state_next  = ST_CHKN;
                end
            end
            ST_CHKN: begin
                alu_a = sext32(v_reg);
                alu_b = sext32(x_rdata);
                if (!diff_neg) begin
                    region_next = tli_pkg::REGION_ABOVE;
                    res_next    = edge_y;
                    state_next  = ST_DONE;
                end else begin
                    k_next     = AW'(1);
                    x_raddr    = AW'(1);
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                alu_a = sext32(v_reg);
                alu_b = sext32(x_rdata);
                if (!diff_neg && !diff_zero && (k_reg < last_reg)) begin
                    x_prev_next = x_rdata;
                    k_next      = k_reg + AW'(1);
                    x_raddr     = k_reg + AW'(1);
                end else begin
                    x1_next    = x_rdata;
                    y_raddr    = k_reg - AW'(1);
                    state_next = ST_NUM;
                end
            end
            ST_NUM: begin
                alu_a      = sext32(v_reg);
                alu_b      = sext32(x_prev_reg);
                rem_next   = alu_y[33:0];
                y0_next    = y_rdata;
                y_raddr    = k_reg;
                state_next = ST_DEN;
            end
            ST_DEN: begin
                alu_a      = sext32(x1_reg);
                alu_b      = sext32(x_prev_reg);
                den_next   = alu_y[32:0];
                y1_next    = y_rdata;
                state_next = ST_DY;
            end
            ST_DY: begin
                alu_a      = sext32(y1_reg);
                alu_b      = sext32(y0_reg);
                dy_next    = alu_y[32:0];
                cnt_next   = 5'd16;
                acc_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                alu_a    = ACC_W'(rem_reg);
                alu_b    = ACC_W'(den_reg);
                q_next   = {q_reg[15:0], q_bit};
                rem_next = q_bit ? {alu_y[32:0], 1'b0} : {rem_reg[32:0], 1'b0};
                if (cnt_reg == '0) begin
                    cnt_next   = 5'd16;
                    state_next = ST_MUL;
                end else begin
                    cnt_next = cnt_reg - 5'd1;
                end
            end
            ST_MUL: begin
                alu_op   = tli_pkg::ALU_ADD;
                alu_a    = {acc_reg[ACC_W-2:0], 1'b0};
                alu_b    = q_reg[cnt_reg] ? sext33(dy_reg) : '0;
                acc_next = alu_y;
                if (cnt_reg == '0) begin
                    state_next = ST_SUM;
                end else begin
                    cnt_next = cnt_reg - 5'd1;
                end
            end
            ST_SUM: begin
                alu_op      = tli_pkg::ALU_ADD;
                alu_a       = sext32(y0_reg);
                alu_b       = {{16{acc_reg[ACC_W-1]}}, acc_reg[ACC_W-1:16]};
                res_next    = alu_y[31:0];
                region_next = tli_pkg::REGION_INTERIOR;
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0,
                                     interior ? q_reg : 17'd0,
                                     interior ? tli_pkg::SEG_W'(k_reg) : 6'd0,
                                     res_reg};
                    m_tuser_next  = region_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            cnt_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        v_reg       <= v_next;
        last_reg    <= last_next;
        k_reg       <= k_next;
        x_prev_reg  <= x_prev_next;
        x1_reg      <= x1_next;
        y0_reg      <= y0_next;
        y1_reg      <= y1_next;
        rem_reg     <= rem_next;
        den_reg     <= den_next;
        dy_reg      <= dy_next;
        q_reg       <= q_next;
        acc_reg     <= acc_next;
        res_reg     <= res_next;
        region_reg  <= region_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `ASSERT_IMPLIES(a_out_from_done, aclk, aresetn, $rose(m_tvalid), $past(state_reg == ST_DONE))
    `ASSERT_IMPLIES(a_edge_fields_zero, aclk, aresetn, m_tvalid && (m_tuser != tli_pkg::REGION_INTERIOR), m_tdata[54:32] == '0)
    `ASSERT_IMPLIES(a_frac_range, aclk, aresetn, m_tvalid && (m_tuser == tli_pkg::REGION_INTERIOR), m_tdata[54:38] <= 17'd65536)
    `ASSERT_IMPLIES(a_step_count, aclk, aresetn, (state_reg == ST_DIV) || (state_reg == ST_MUL), cnt_reg <= 5'd16)

endmodule

// ===== rtl/tli_alu.sv =====
// ---------------------------------------------------------------------------
// tli_alu
// Shared add/subtract unit used for compares, divide and multiply steps.
// ---------------------------------------------------------------------------
module tli_alu (
    input  tli_pkg::alu_op_t                alu_op,
    input  logic [tli_pkg::ACC_W-1:0]       op_a,
    input  logic [tli_pkg::ACC_W-1:0]       op_b,
    output logic [tli_pkg::ACC_W-1:0]       result
);

    always_comb begin
        unique case (alu_op)
            tli_pkg::ALU_ADD: result = op_a + op_b;
            tli_pkg::ALU_SUB: result = op_a - op_b;
            default:          result = op_a + op_b;
        endcase
    end

endmodule

// ===== rtl/tli_table.sv =====
// ---------------------------------------------------------------------------
// tli_table
// Breakpoint storage: x and y memories, one write port, registered reads.
// ---------------------------------------------------------------------------
module tli_table #(
    parameter  int unsigned MAX_POINTS = tli_pkg::MAX_POINTS_DEF,
    localparam int unsigned AW         = $clog2(MAX_POINTS)
) (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [AW-1:0]                 wr_addr,
    input  logic [tli_pkg::DATA_W-1:0]    wr_x,
    input  logic [tli_pkg::DATA_W-1:0]    wr_y,
    input  logic [AW-1:0]                 x_raddr,
    input  logic [AW-1:0]                 y_raddr,
    output logic [tli_pkg::DATA_W-1:0]    x_rdata,
    output logic [tli_pkg::DATA_W-1:0]    y_rdata
);

    logic [tli_pkg::DATA_W-1:0] x_mem [MAX_POINTS];
    logic [tli_pkg::DATA_W-1:0] y_mem [MAX_POINTS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            x_mem[wr_addr] <= wr_x;
            y_mem[wr_addr] <= wr_y;
        end
    end

    always_ff @(posedge aclk) begin
        x_rdata <= x_mem[x_raddr];
        y_rdata <= y_mem[y_raddr];
    end

endmodule

// ===== bench/table_linear_interpolator_top_test.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// table_linear_interpolator_top_test
// Self-checking bench for the breakpoint table interpolator. A queue of
// breakpoint loads, queries and register writes feeds a clocked driver; a
// clocked monitor predicts every query result from its own copy of the table
// and registers and checks the output stream in order. Both sides idle at
// random; register writes only happen once the block has drained.
// ---------------------------------------------------------------------------
module table_linear_interpolator_top_test;

    localparam logic [tli_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1800;
    localparam int DRAIN_CYCLES = 128;
    localparam int STALL_LIMIT  = 2000;
    localparam longint Q_MIN = -(64'sd1 <<< 31);
    localparam longint Q_MAX = (64'sd1 <<< 31) - 1;
    localparam int COUNT_PICKS [6] = '{2, 1, 64, 0, 127, 3};

    typedef enum logic [1:0] {
        ST_ITEM,
        ST_CFG,
        ST_DRAIN
    } step_kind_t;

    typedef struct {
        step_kind_t     kind;
        logic           op;
        logic [5:0]     idx;
        logic [31:0]    px;
        logic [31:0]    py;
        logic [31:0]    qv;
        logic [1:0]     reg_idx;
        logic [31:0]    reg_data;
    } stim_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic [1:0]         region;
        logic [5:0]         seg;
        logic [16:0]        frac;
    } interp_t;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [tli_pkg::S_TDATA_W-1:0]   s_tdata   = '0;
    logic [0:0]                      s_tuser   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [tli_pkg::M_TDATA_W-1:0]   m_tdata;
    logic [1:0]                      m_tuser;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [tli_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [tli_pkg::DATA_W-1:0]      cfg_data  = '0;

    table_linear_interpolator_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // predictor state
    logic signed [31:0] tbl_x [64];
    logic signed [31:0] tbl_y [64];
    logic [6:0]         cfg_count    = 7'd1;
    logic               cfg_fill_en  = 1'b0;
    logic signed [31:0] cfg_fill_val = '0;
    interp_t            expect_q [$];

    // generator state
    stim_t              pending_q [$];
    logic signed [31:0] gen_x [64];
    int                 gen_count = 1;

    int                 err_count    = 0;
    int                 quiet_cycles = 0;
    int                 tx_gap       = 0;
    bit                 tx_calm      = 1'b0;
    int                 drain_quiet  = 0;
    int                 rx_stall     = 0;
    bit                 rx_calm      = 1'b0;

    function automatic interp_t interpolate(logic signed [31:0] v);
        interp_t r;
        int n, k;
        longint x0, x1, y0, y1, num, den, t;
        r = '0;
        n = cfg_count;
        if (n < 1) n = 1;
        if (n > 64) n = 64;
        if (v <= tbl_x[0]) begin
            r.region = tli_pkg::REGION_BELOW;
            r.value  = cfg_fill_en ? cfg_fill_val : tbl_y[0];
        end else if (v >= tbl_x[n-1]) begin
            r.region = tli_pkg::REGION_ABOVE;
            r.value  = cfg_fill_en ? cfg_fill_val : tbl_y[n-1];
        end else begin
            k = 1;
            while (k < n - 1 && tbl_x[k] < v) k++;
            x0 = tbl_x[k-1];
            x1 = tbl_x[k];
            y0 = tbl_y[k-1];
            y1 = tbl_y[k];
            num = longint'(v) - x0;
            den = x1 - x0;
            t = (num <<< 16) / den;
            r.region = tli_pkg::REGION_INTERIOR;
            r.value  = 32'(y0 + ((t * (y1 - y0)) >>> 16));
            r.seg    = 6'(k);
            r.frac   = 17'(t);
        end
        return r;
    endfunction

    function automatic int gen_n();
        if (gen_count < 1) return 1;
        if (gen_count > 64) return 64;
        return gen_count;
    endfunction

    function automatic void push_load(int idx, logic [31:0] x, logic [31:0] y);
        stim_t e;
        e = '{kind: ST_ITEM, op: tli_pkg::OP_LOAD, idx: 6'(idx), px: x, py: y,
              qv: $urandom, reg_idx: '0, reg_data: '0};
        gen_x[idx] = x;
        pending_q.push_back(e);
    endfunction

    function automatic void push_query(logic [31:0] v);
        stim_t e;
        e = '{kind: ST_ITEM, op: tli_pkg::OP_QUERY, idx: 6'($urandom), px: $urandom,
              py: $urandom, qv: v, reg_idx: '0, reg_data: '0};
        pending_q.push_back(e);
    endfunction

    function automatic void push_cfg(logic [tli_pkg::CFG_IDX_W-1:0] r, logic [31:0] d);
        stim_t e;
        e = '{kind: ST_CFG, op: tli_pkg::OP_LOAD, idx: '0, px: '0, py: '0, qv: '0,
              reg_idx: r, reg_data: d};
        if (r == tli_pkg::REG_POINT_COUNT) gen_count = int'(d[6:0]);
        pending_q.push_back(e);
    endfunction

    function automatic void push_drain();
        stim_t e;
        e = '{kind: ST_DRAIN, op: tli_pkg::OP_LOAD, idx: '0, px: '0, py: '0, qv: '0,
              reg_idx: '0, reg_data: '0};
        pending_q.push_back(e);
    endfunction

    function automatic void reconfigure(int count, bit fill_en, logic [31:0] fill_val);
        push_drain();
        push_cfg(tli_pkg::REG_POINT_COUNT, 32'(count & 'h7F));
        push_cfg(tli_pkg::REG_USE_FILL, {31'b0, fill_en});
        push_cfg(tli_pkg::REG_FILL_VALUE, fill_val);
    endfunction

    // n breakpoints, mostly sorted, loaded in shuffled slot order
    function automatic void load_table(int n);
        int xs [$];
        int order [$];
        logic [31:0] mask, offs, y;
        case ($urandom_range(0, 3))
            0: mask = 32'hFFFF_FFFF;
            1: mask = 32'h00FF_FFFF;
            2: mask = 32'h0000_FFFF;
            default: mask = 32'h0000_000F;
        endcase
        offs = (mask == 32'hFFFF_FFFF) ? 32'h0 : $urandom;
        for (int i = 0; i < n; i++) begin
            xs.push_back(int'(($urandom & mask) + offs));
            order.push_back(i);
        end
        if ($urandom_range(0, 7) != 0) xs.sort();
        order.shuffle();
        foreach (order[i]) begin
            y = ($urandom_range(0, 1) != 0) ? $urandom : ($urandom & 32'h000F_FFFF) - 32'h0008_0000;
            push_load(order[i], xs[order[i]], y);
        end
    endfunction

    function automatic logic [31:0] rand_query();
        int n, j;
        longint lo, hi, v, sw;
        longint unsigned r;
        n = gen_n();
        j = $urandom_range(0, n - 1);
        r = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: v = int'($urandom);
            1: v = gen_x[j];
            2: v = longint'(gen_x[j]) + int'($urandom_range(0, 6)) - 3;
            default: begin
                lo = gen_x[0];
                hi = gen_x[n-1];
                if (lo > hi) begin
                    sw = lo;
                    lo = hi;
                    hi = sw;
                end
                v = lo + longint'(r % longint'(hi - lo + 1));
            end
        endcase
        if (v < Q_MIN) v = Q_MIN;
        if (v > Q_MAX) v = Q_MAX;
        return v[31:0];
    endfunction

    always @(posedge aclk) begin : driver
        stim_t ent;
        logic  sv, cv;
        sv = s_tvalid && !s_tready;
        cv = cfg_valid && !cfg_ready;
        if (!aresetn) begin
            sv = 1'b0;
            cv = 1'b0;
        end else if (!sv && !cv) begin
            if (tx_gap > 0) begin
                tx_gap--;
            end else if (pending_q.size() != 0) begin
                ent = pending_q[0];
                if (ent.kind == ST_DRAIN) begin
                    drain_quiet = (expect_q.size() == 0) ? drain_quiet + 1 : 0;
                    if (drain_quiet >= DRAIN_CYCLES) begin
                        void'(pending_q.pop_front());
                        drain_quiet = 0;
                    end
                end else begin
                    void'(pending_q.pop_front());
                    if (ent.kind == ST_ITEM) begin
                        s_tuser <= ent.op;
                        s_tdata <= {2'b00, ent.qv, ent.py, ent.px, ent.idx};
                        sv = 1'b1;
                    end else begin
                        cfg_index <= ent.reg_idx;
                        cfg_data  <= ent.reg_data;
                        cv = 1'b1;
                    end
                    tx_gap = tx_calm ? 0 : $urandom_range(0, 12);
                    if ($urandom_range(0, 63) == 0) tx_calm = !tx_calm;
                end
            end
        end
        s_tvalid  <= sv;
        cfg_valid <= cv;
    end

    always @(posedge aclk) begin : monitor
        interp_t got, want;
        logic    rdy;
        if (aresetn && m_tvalid && m_tready) begin
            got.value  = m_tdata[31:0];
            got.seg    = m_tdata[37:32];
            got.frac   = m_tdata[54:38];
            got.region = m_tuser;
            if (expect_q.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected result: value %h region %0d seg %0d frac %h",
                             got.value, got.region, got.seg, got.frac);
            end else begin
                want = expect_q.pop_front();
                if (got !== want) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("mismatch: expected %h/%0d/%0d/%h, got %h/%0d/%0d/%h",
                                 want.value, want.region, want.seg, want.frac,
                                 got.value, got.region, got.seg, got.frac);
                end
            end
            rx_stall = rx_calm ? 0 : $urandom_range(0, 12);
            if ($urandom_range(0, 49) == 0) rx_calm = !rx_calm;
        end
        if (aresetn && cfg_valid && cfg_ready) begin
            case (cfg_index)
                tli_pkg::REG_POINT_COUNT: cfg_count    = cfg_data[6:0];
                tli_pkg::REG_USE_FILL:    cfg_fill_en  = cfg_data[0];
                tli_pkg::REG_FILL_VALUE:  cfg_fill_val = cfg_data;
                default: ;
            endcase
        end
        if (aresetn && s_tvalid && s_tready) begin
            if (s_tuser[0] == tli_pkg::OP_LOAD) begin
                tbl_x[s_tdata[5:0]] = s_tdata[37:6];
                tbl_y[s_tdata[5:0]] = s_tdata[69:38];
            end else begin
                expect_q.push_back(interpolate(s_tdata[101:70]));
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (rx_stall > 0) begin
            rx_stall--;
            rdy = 1'b0;
        end else begin
            rdy = 1'b1;
        end
        m_tready <= rdy;
    end

    initial begin : watchdog
        while (quiet_cycles < STALL_LIMIT) @(posedge aclk);
        $display("table_linear_interpolator_top_test: errors");
        $finish;
    end

    initial begin : stimulus
        int rand_items, phase, count, len;
        bit fill_en;
        logic [31:0] fv;
        rand_items = 0;
        phase = 0;

        // single point: both edges
        push_load(0, 32'h0000_0000, 32'h0001_0000);
        push_query(32'h8000_0000);
        push_query(32'h0000_0000);
        push_query(32'h7FFF_FFFF);
        push_query(32'h0000_0001);
        // four points with extreme coordinates and a zero-width segment
        reconfigure(4, 1'b0, 32'h0);
        push_load(1, 32'h0001_0000, 32'h8000_0000);
        push_load(2, 32'h0001_0000, 32'h7FFF_FFFF);
        push_load(3, 32'h7FFF_FFFF, 32'hFFFF_0000);
        push_load(0, 32'h8000_0000, 32'h7FFF_FFFF);
        push_query(32'h8000_0001);
        push_query(32'h0000_8000);
        push_query(32'h0001_0000);
        push_query(32'h0001_0001);
        push_query(32'h7FFF_FFFE);
        push_query(32'h7FFF_FFFF);
        push_query(32'h8000_0000);
        // fill outside the range
        reconfigure(4, 1'b1, 32'h8000_0000);
        push_query(32'h8000_0000);
        push_query(32'h7FFF_FFFF);
        push_query(32'h4000_0000);
        // write to a nonexistent register
        push_drain();
        push_cfg(REG_UNUSED, 32'hFFFF_FFFF);
        push_query(32'h8000_0000);
        // unsorted table
        push_load(1, 32'h7FFF_FFFF, 32'h0000_1234);
        push_query(32'h0002_0000);
        // zero count acts as one point
        reconfigure(0, 1'b0, 32'h7FFF_FFFF);
        push_query(32'h0000_0005);
        push_query(32'h8000_0000);

        while (rand_items < RANDOM_ITEMS) begin
            if (phase < 6)
                count = COUNT_PICKS[phase];
            else if ($urandom_range(0, 3) == 0)
                count = $urandom_range(1, 64);
            else
                count = $urandom_range(2, 8);
            fill_en = $urandom_range(0, 1);
            case ($urandom_range(0, 3))
                0: fv = 32'h8000_0000;
                1: fv = 32'h7FFF_FFFF;
                default: fv = $urandom;
            endcase
            reconfigure(count, fill_en, fv);
            if ($urandom_range(0, 3) == 0) push_cfg(REG_UNUSED, $urandom);
            load_table(gen_n());
            rand_items += gen_n();
            len = $urandom_range(80, 160);
            repeat (len) begin
                if ($urandom_range(0, 7) == 0)
                    push_load($urandom_range(0, 63), $urandom, $urandom);
                else
                    push_query(rand_query());
                rand_items++;
                if ($urandom_range(0, 99) == 0) push_drain();
            end
            phase++;
        end
        // final drain doubles as the end-of-run settle time
        push_drain();

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        while (pending_q.size() != 0) @(posedge aclk);
        @(posedge aclk);
        if (err_count == 0)
            $display("table_linear_interpolator_top_test: clean");
        else
            $display("table_linear_interpolator_top_test: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/tli_pkg.sv
rtl/tli_alu.sv
rtl/tli_table.sv
rtl/table_linear_interpolator_top.sv
bench/table_linear_interpolator_top_test.sv
